// ===== hdl/imrt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the I2C register transfer master.
package imrt_pkg;

  localparam int unsigned MAX_ADDR_BYTES = 4;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd5;
  localparam logic [7:0]  ACK_POLL_RESET    = 8'd250;
  localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

  typedef enum logic [1:0] {
    FN_TICK     = 2'd0,
    FN_START_WR = 2'd1,
    FN_START_RD = 2'd2,
    FN_WR_BYTE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ADDR_NACK = 2'd1,
    ST_DATA_NACK = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    CFG_HALF_PERIOD = 1'd0,
    CFG_ACK_POLL    = 1'd1
  } cfg_index_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_ST_A  = 4'd1,
    PH_ST_B  = 4'd2,
    PH_TX_LO = 4'd3,
    PH_TX_HI = 4'd4,
    PH_ACK_W = 4'd5,
    PH_NEED  = 4'd6,
    PH_RX_LO = 4'd7,
    PH_RX_HI = 4'd8,
    PH_MA_LO = 4'd9,
    PH_MA_HI = 4'd10,
    PH_NA_LO = 4'd11,
    PH_NA_HI = 4'd12,
    PH_SP_A  = 4'd13,
    PH_SP_B  = 4'd14,
    PH_FIN   = 4'd15
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DEVW  = 2'd0,
    KIND_MEM   = 2'd1,
    KIND_DATA  = 2'd2,
    KIND_RDDEV = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [6:0]  dev_address;
    logic [31:0] mem_address;
    logic [2:0]  mem_address_bytes;
    logic [7:0]  transfer_length;
    logic [7:0]  data_byte;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       need_byte;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] bytes_done;
  } out_item_t;

  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [7:0]  ack_poll_limit;
  } cfg_regs_t;

endpackage

// ===== hdl/imrt_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command items, results and configuration.
interface imrt_in_if import imrt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface imrt_out_if import imrt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface imrt_cfg_if import imrt_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/imrt_engine.sv =====
`timescale 1ns / 1ps
// Bus sequencer state and its one-tick step logic.
module imrt_engine import imrt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_regs_t cfg,
  output out_item_t res
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] hpc_r, hpc_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  bc_r, bc_nxt;
  logic [7:0]  apc_r, apc_nxt;
  logic [6:0]  dev_r, dev_nxt;
  logic [31:0] mem_r, mem_nxt;
  logic [2:0]  nb_r, nb_nxt;
  logic [7:0]  len_r, len_nxt;
  logic        rd_r, rd_nxt;
  logic [2:0]  abi_r, abi_nxt;
  kind_t       kind_r, kind_nxt;
  logic        restart_r, restart_nxt;
  logic        second_r, second_nxt;
  logic [1:0]  outcome_r, outcome_nxt;

  logic [15:0] hl;
  logic [16:0] cnt_inc;
  logic        slot_done;
  logic [15:0] hpc_slot;
  logic [15:0] hpc_ack;
  logic [2:0]  abi_eff;
  logic        addr_more;
  logic [2:0]  byte_sel;
  logic [7:0]  mem_byte;
  logic [3:0]  bit_inc;
  logic [7:0]  bc_inc;
  logic [7:0]  rx_shift;
  logic        rx_sample;
  logic [3:0]  bit_after;
  logic [7:0]  bc_after;
  logic [2:0]  nb_in;

  always_comb begin
    hl        = (cfg.half_period_ticks == '0) ? 16'd1 : cfg.half_period_ticks;
    cnt_inc   = {1'b0, hpc_r} + 17'd1;
    slot_done = cnt_inc >= {1'b0, hl};
    hpc_slot  = slot_done ? '0 : cnt_inc[15:0];
    hpc_ack   = (hpc_r < hl) ? cnt_inc[15:0] : hpc_r;
    abi_eff   = (kind_r == KIND_DEVW) ? '0 : abi_r + 3'd1;
    addr_more = abi_eff < nb_r;
    byte_sel  = nb_r - 3'd1 - abi_eff;
    case (byte_sel[1:0])
      2'd0:    mem_byte = mem_r[7:0];
      2'd1:    mem_byte = mem_r[15:8];
      2'd2:    mem_byte = mem_r[23:16];
      default: mem_byte = mem_r[31:24];
    endcase
    bit_inc   = bit_r + 4'd1;
    bc_inc    = bc_r + 8'd1;
    rx_shift  = {shift_r[6:0], item.sda_in};
    rx_sample = (hpc_r == '0) && (bit_r < BITS_PER_BYTE);
    bit_after = rx_sample ? bit_inc : bit_r;
    bc_after  = (rx_sample && (bit_inc == BITS_PER_BYTE)) ? bc_inc : bc_r;
    nb_in     = (item.mem_address_bytes > 3'(MAX_ADDR_BYTES)) ?
                3'(MAX_ADDR_BYTES) : item.mem_address_bytes;
  end

  always_comb begin
    phase_nxt   = phase_r;
    hpc_nxt     = hpc_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    bc_nxt      = bc_r;
    apc_nxt     = apc_r;
    dev_nxt     = dev_r;
    mem_nxt     = mem_r;
    nb_nxt      = nb_r;
    len_nxt     = len_r;
    rd_nxt      = rd_r;
    abi_nxt     = abi_r;
    kind_nxt    = kind_r;
    restart_nxt = restart_r;
    second_nxt  = second_r;
    outcome_nxt = outcome_r;

    res = '0;
    res.scl_level = 1'b1;
    res.busy_res  = 1'b1;

    case (phase_r)
      PH_ST_A: begin
        hpc_nxt = hpc_slot;
        if (slot_done) phase_nxt = PH_ST_B;
      end
      PH_ST_B: begin
        res.sda_pull_low = 1'b1;
        hpc_nxt = hpc_slot;
        if (slot_done) begin
          shift_nxt = {dev_r, second_r};
          kind_nxt  = second_r ? KIND_RDDEV : KIND_DEVW;
          bit_nxt   = '0;
          phase_nxt = PH_TX_LO;
        end
      end
      PH_TX_LO: begin
        res.scl_level    = 1'b0;
        res.sda_pull_low = ~shift_r[7];
        hpc_nxt = hpc_slot;
        if (slot_done) phase_nxt = PH_TX_HI;
      end
      PH_TX_HI: begin
        res.sda_pull_low = ~shift_r[7];
        hpc_nxt = hpc_slot;
        if (slot_done) begin
          shift_nxt = {shift_r[6:0], 1'b0};
          bit_nxt   = bit_inc;
          if (bit_inc >= BITS_PER_BYTE) begin
            apc_nxt   = '0;
            phase_nxt = PH_ACK_W;
          end else begin
            phase_nxt = PH_TX_LO;
          end
        end
      end
      PH_ACK_W: begin
        hpc_nxt = hpc_ack;
        if (hpc_ack >= hl) begin
          if (!item.sda_in) begin
            hpc_nxt = '0;
            case (kind_r)
              KIND_DEVW, KIND_MEM: begin
                abi_nxt = abi_eff;
                if (addr_more) begin
                  shift_nxt = mem_byte;
                  kind_nxt  = KIND_MEM;
                  bit_nxt   = '0;
                  phase_nxt = PH_TX_LO;
                end else if (rd_r) begin
                  restart_nxt = 1'b1;
                  phase_nxt   = PH_SP_A;
                end else if (bc_r < len_r) begin
                  phase_nxt = PH_NEED;
                end else begin
                  outcome_nxt = ST_OK;
                  phase_nxt   = PH_SP_A;
                end
              end
              KIND_DATA: begin
                bc_nxt = bc_inc;
                if (bc_inc < len_r) begin
                  phase_nxt = PH_NEED;
                end else begin
                  outcome_nxt = ST_OK;
                  phase_nxt   = PH_SP_A;
                end
              end
              default: begin
                bc_nxt = '0;
                if (len_r == '0) begin
                  outcome_nxt = ST_OK;
                  phase_nxt   = PH_SP_A;
                end else begin
                  bit_nxt   = '0;
                  shift_nxt = '0;
                  phase_nxt = PH_RX_LO;
                end
              end
            endcase
          end else if (apc_r >= cfg.ack_poll_limit) begin
            hpc_nxt     = '0;
            outcome_nxt = (kind_r == KIND_DATA) ? ST_DATA_NACK : ST_ADDR_NACK;
            phase_nxt   = PH_SP_A;
          end else begin
            apc_nxt = apc_r + 8'd1;
          end
        end
      end
      PH_NEED: begin
        res.scl_level = 1'b0;
        res.need_byte = 1'b1;
        if (item.func == FN_WR_BYTE) begin
          shift_nxt = item.data_byte;
          kind_nxt  = KIND_DATA;
          bit_nxt   = '0;
          hpc_nxt   = '0;
          phase_nxt = PH_TX_LO;
        end
      end
      PH_RX_LO: begin
        res.scl_level = 1'b0;
        hpc_nxt = hpc_slot;
        if (slot_done) phase_nxt = PH_RX_HI;
      end
      PH_RX_HI: begin
        if (rx_sample) begin
          shift_nxt = rx_shift;
          bit_nxt   = bit_inc;
          if (bit_inc == BITS_PER_BYTE) begin
            res.read_valid = 1'b1;
            res.read_byte  = rx_shift;
            bc_nxt         = bc_inc;
          end
        end
        hpc_nxt = hpc_slot;
        if (slot_done) begin
          if (bit_after >= BITS_PER_BYTE)
            phase_nxt = (bc_after < len_r) ? PH_MA_LO : PH_NA_LO;
          else
            phase_nxt = PH_RX_LO;
        end
      end
      PH_MA_LO: begin
        res.scl_level    = 1'b0;
        res.sda_pull_low = 1'b1;
        hpc_nxt = hpc_slot;
        if (slot_done) phase_nxt = PH_MA_HI;
      end
      PH_MA_HI: begin
        res.sda_pull_low = 1'b1;
        hpc_nxt = hpc_slot;
        if (slot_done) begin
          bit_nxt   = '0;
          shift_nxt = '0;
          phase_nxt = PH_RX_LO;
        end
      end
      PH_NA_LO: begin
        res.scl_level = 1'b0;
        hpc_nxt = hpc_slot;
        if (slot_done) phase_nxt = PH_NA_HI;
      end
      PH_NA_HI: begin
        hpc_nxt = hpc_slot;
        if (slot_done) begin
          outcome_nxt = ST_OK;
          phase_nxt   = PH_SP_A;
        end
      end
      PH_SP_A: begin
        res.scl_level    = 1'b0;
        res.sda_pull_low = 1'b1;
        hpc_nxt = hpc_slot;
        if (slot_done) phase_nxt = PH_SP_B;
      end
      PH_SP_B: begin
        res.sda_pull_low = 1'b1;
        hpc_nxt = hpc_slot;
        if (slot_done) begin
          if (restart_r) begin
            restart_nxt = 1'b0;
            second_nxt  = 1'b1;
            phase_nxt   = PH_ST_A;
          end else begin
            phase_nxt = PH_FIN;
          end
        end
      end
      default: begin
        // idle and finish ticks: report the outcome once, take a new request
        res.busy_res = 1'b0;
        if (phase_r == PH_FIN) begin
          res.done_res   = 1'b1;
          res.status     = outcome_r;
          res.bytes_done = bc_r;
        end
        hpc_nxt   = '0;
        phase_nxt = PH_IDLE;
        if (item.func == FN_START_WR || item.func == FN_START_RD) begin
          dev_nxt     = item.dev_address;
          mem_nxt     = item.mem_address;
          nb_nxt      = nb_in;
          len_nxt     = item.transfer_length;
          rd_nxt      = (item.func == FN_START_RD);
          bc_nxt      = '0;
          bit_nxt     = '0;
          shift_nxt   = '0;
          apc_nxt     = '0;
          abi_nxt     = '0;
          restart_nxt = 1'b0;
          second_nxt  = 1'b0;
          outcome_nxt = ST_OK;
          phase_nxt   = PH_ST_A;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      hpc_r     <= '0;
      bit_r     <= '0;
      shift_r   <= '0;
      bc_r      <= '0;
      apc_r     <= '0;
      dev_r     <= '0;
      mem_r     <= '0;
      nb_r      <= '0;
      len_r     <= '0;
      rd_r      <= 1'b0;
      abi_r     <= '0;
      kind_r    <= KIND_DEVW;
      restart_r <= 1'b0;
      second_r  <= 1'b0;
      outcome_r <= ST_OK;
    end else if (step) begin
      phase_r   <= phase_nxt;
      hpc_r     <= hpc_nxt;
      bit_r     <= bit_nxt;
      shift_r   <= shift_nxt;
      bc_r      <= bc_nxt;
      apc_r     <= apc_nxt;
      dev_r     <= dev_nxt;
      mem_r     <= mem_nxt;
      nb_r      <= nb_nxt;
      len_r     <= len_nxt;
      rd_r      <= rd_nxt;
      abi_r     <= abi_nxt;
      kind_r    <= kind_nxt;
      restart_r <= restart_nxt;
      second_r  <= second_nxt;
      outcome_r <= outcome_nxt;
    end
  end

endmodule

// ===== hdl/i2c_master_register_transfer.sv =====
`timescale 1ns / 1ps
// Top level of the I2C register transfer master: input stage, sequencer, result register.
//
//  Channel   Dir  Carries
//  in_ch     in   one tick or command per transfer: func, request operands, sda_in
//  out_ch    out  one result per input transfer: pin levels, status, read data
//  cfg_ch    in   register index and data (0 half_period_ticks, 1 ack_poll_limit)
//
// Each input transfer advances the bus sequencer by one tick; one item is taken
// per clock while results are taken, and its result is offered through the input
// stage register, then the result register behind the step logic.
// rst_n is synchronous: it empties both stages, idles the sequencer and loads
// the configuration defaults (half period 5, poll limit 250).
// While out_ch.ready is low the result holds, the input stage fills, and
// in_ch.ready drops until the result is taken. cfg_ch always accepts.
module i2c_master_register_transfer import imrt_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  imrt_in_if.sink   in_ch,
  imrt_out_if.source out_ch,
  imrt_cfg_if.sink  cfg_ch
);

  logic      in_v_r;
  in_item_t  in_item_r;
  logic      out_v_r;
  out_item_t out_item_r;
  cfg_regs_t cfg_r;
  logic      step;
  out_item_t step_res;

  // advance the sequencer when the result slot is free or being drained
  assign step         = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !in_v_r || step;
  assign out_ch.valid = out_v_r;
  assign out_ch.item  = out_item_r;
  assign cfg_ch.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period_ticks <= HALF_PERIOD_RESET;
      cfg_r.ack_poll_limit    <= ACK_POLL_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_HALF_PERIOD: cfg_r.half_period_ticks <= cfg_ch.data;
        CFG_ACK_POLL:    cfg_r.ack_poll_limit    <= cfg_ch.data[7:0];
        default:         cfg_r <= cfg_r;
      endcase
    end
  end

  // input stage: load on every accepted transfer, drop when stepped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_v_r <= 1'b1;
    end else if (step) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) in_item_r <= in_ch.item;
  end

  imrt_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_item_r),
    .cfg   (cfg_r),
    .res   (step_res)
  );

  // result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_item_r <= step_res;
  end

  // a stage that cannot advance keeps its item
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !step |=> in_v_r)
    else $error("input stage lost an item");

  // a finished transaction is never reported as still busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_item_r.done_res |-> !out_item_r.busy_res)
    else $error("done reported while busy");

  // received bytes only show up inside a transaction
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_item_r.read_valid |-> out_item_r.busy_res)
    else $error("read byte outside a transaction");

  // while waiting for a write byte, SCL is low and SDA is released
  a_need_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_item_r.need_byte |->
      !out_item_r.scl_level && !out_item_r.sda_pull_low)
    else $error("bad pin levels while waiting for a byte");

  // status and count appear only with done
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_item_r.done_res |->
      out_item_r.status == ST_OK && out_item_r.bytes_done == '0)
    else $error("outcome shown without done");

endmodule
